// ----- sv/mcol_pkg.sv -----
`default_nettype none

package mcol_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT_CODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_WIDTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_HEIGHT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_COUNT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IS_CUBE       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STORAGE_READY = 3'd5;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned SIDE_W     = 16;
   localparam int unsigned BYTES_W    = 32;
   localparam int unsigned FACE_CNT_W = 3;

   localparam logic [7:0] CUBE_FACES = 8'd6;
   localparam logic [7:0] FLAT_FACES = 8'd1;

   // Pixel formats
   localparam logic [3:0] FMT_ARGB8 = 4'd0;
   localparam logic [3:0] FMT_XRGB8 = 4'd1;
   localparam logic [3:0] FMT_A8L8  = 4'd2;
   localparam logic [3:0] FMT_L8    = 4'd3;
   localparam logic [3:0] FMT_A8    = 4'd4;
   localparam logic [3:0] FMT_DXT1  = 4'd5;
   localparam logic [3:0] FMT_DXT3  = 4'd6;
   localparam logic [3:0] FMT_DXT5  = 4'd7;

   // Block formats round each side up to whole 4x4 blocks
   localparam logic [SIDE_W:0] BLOCK_ROUND = 17'd3;

   // Result status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_SOURCE = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEVEL = 3'd2;
   localparam logic [2:0] STATUS_BAD_FACE  = 3'd3;
   localparam logic [2:0] STATUS_TOO_LARGE = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SIZE = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_FACE = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ----- sv/mcol_level_size.sv -----
`default_nettype none

// Byte size of one mip level: one 16x16 multiply, then a shift by the
// bytes per pixel or per block.
module mcol_level_size (
   input  wire logic [3:0]                    format_code,
   input  wire logic [mcol_pkg::SIDE_W-1:0]   width,
   input  wire logic [mcol_pkg::SIDE_W-1:0]   height,
   output logic      [mcol_pkg::BYTES_W-1:0]  level_bytes
);

   logic [mcol_pkg::SIDE_W:0]    w_round;
   logic [mcol_pkg::SIDE_W:0]    h_round;
   logic [mcol_pkg::SIDE_W-1:0]  op_a;
   logic [mcol_pkg::SIDE_W-1:0]  op_b;
   logic [mcol_pkg::BYTES_W-1:0] product;
   logic                         blocked;

   always_comb begin
      w_round = {1'b0, width} + mcol_pkg::BLOCK_ROUND;
      h_round = {1'b0, height} + mcol_pkg::BLOCK_ROUND;
      blocked = (format_code == mcol_pkg::FMT_DXT1) ||
                (format_code == mcol_pkg::FMT_DXT3) ||
                (format_code == mcol_pkg::FMT_DXT5);
      if (blocked) begin
         op_a = {1'b0, w_round[mcol_pkg::SIDE_W:2]};
         op_b = {1'b0, h_round[mcol_pkg::SIDE_W:2]};
      end else begin
         op_a = width;
         op_b = height;
      end
      product = {{mcol_pkg::SIDE_W{1'b0}}, op_a} * {{mcol_pkg::SIDE_W{1'b0}}, op_b};
   end

   always_comb begin
      unique case (format_code)
         mcol_pkg::FMT_ARGB8,
         mcol_pkg::FMT_XRGB8: level_bytes = product << 2;
         mcol_pkg::FMT_A8L8:  level_bytes = product << 1;
         mcol_pkg::FMT_L8,
         mcol_pkg::FMT_A8:    level_bytes = product;
         mcol_pkg::FMT_DXT1:  level_bytes = product << 3;
         mcol_pkg::FMT_DXT3,
         mcol_pkg::FMT_DXT5:  level_bytes = product << 4;
         default:             level_bytes = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/mip_chain_offset_locator_unit.sv -----
// Mip chain offset locator.
// Channels: a request is taken at a rising edge with start high and busy
// low; it carries mip level, cube face, source length and a source-present
// flag. The result (status, byte offset, level bytes) appears for exactly
// one cycle with rsp_valid high; the receiver cannot stall it.
// Rejected requests (no storage or source, level or face out of range) raise
// rsp_valid in the cycle right after acceptance and never raise busy, so
// they can be taken one per cycle.
// Accepted requests walk the face chain with one shared size multiplier:
// each level takes a size step, then an accumulate step; for face 0 the
// walk covers levels 0..L, and for a face F > 0 the whole chain of
// level_count levels is summed once and then added F more times by the
// same adder, one add per cycle. busy drops in the result cycle, so the
// next request is taken at the earliest on the edge that takes the result.
// Configuration: csr_we writes register csr_index at the next edge; write
// only while busy is low. Unused indexes are ignored.
// Reset: synchronous, active high; registers return to format 0, 1x1
// base, one level, flat texture, no storage; no result is pending.
`default_nettype none

module mip_chain_offset_locator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [7:0]                          req_mip_level,
   input  wire logic [7:0]                          req_face_index,
   input  wire logic [mcol_pkg::BYTES_W-1:0]        req_source_bytes,
   input  wire logic                                req_source_present,
   // result channel
   output logic                                     rsp_valid,
   output logic [2:0]                               rsp_status,
   output logic [mcol_pkg::BYTES_W-1:0]             rsp_byte_offset,
   output logic [mcol_pkg::BYTES_W-1:0]             rsp_level_bytes,
   // configuration port
   input  wire logic                                csr_we,
   input  wire logic [mcol_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mcol_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic [3:0]                     format_ff;
   logic [mcol_pkg::SIDE_W-1:0]    base_w_ff;
   logic [mcol_pkg::SIDE_W-1:0]    base_h_ff;
   logic [7:0]                     level_count_ff;
   logic                           is_cube_ff;
   logic                           storage_ff;

   // walk state
   mcol_pkg::state_type            state_ff, state_in;
   logic [mcol_pkg::SIDE_W-1:0]    w_ff, w_in;
   logic [mcol_pkg::SIDE_W-1:0]    h_ff, h_in;
   logic [7:0]                     lvl_ff, lvl_in;
   logic [7:0]                     tgt_level_ff, tgt_level_in;
   logic [mcol_pkg::FACE_CNT_W-1:0] face_cnt_ff, face_cnt_in;
   logic [mcol_pkg::BYTES_W-1:0]   src_ff, src_in;
   logic [mcol_pkg::BYTES_W-1:0]   size_ff, size_in;
   logic [mcol_pkg::BYTES_W-1:0]   chain_ff, chain_in;
   logic [mcol_pkg::BYTES_W-1:0]   off_ff, off_in;
   logic [mcol_pkg::BYTES_W-1:0]   lbytes_ff, lbytes_in;

   // result registers
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2:0]                     rsp_status_ff, rsp_status_in;
   logic [mcol_pkg::BYTES_W-1:0]   rsp_off_ff, rsp_off_in;
   logic [mcol_pkg::BYTES_W-1:0]   rsp_bytes_ff, rsp_bytes_in;

   logic [mcol_pkg::BYTES_W-1:0]   unit_size;
   logic [mcol_pkg::BYTES_W-1:0]   add_a;
   logic [mcol_pkg::BYTES_W-1:0]   add_b;
   logic [mcol_pkg::BYTES_W-1:0]   add_sum;
   logic [7:0]                     faces;
   logic                           accept;
   logic                           hit;
   logic                           last;

   assign busy            = (state_ff != mcol_pkg::ST_IDLE);
   assign accept          = start && !busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_byte_offset = rsp_off_ff;
   assign rsp_level_bytes = rsp_bytes_ff;

   // Shared size unit: works on the current side pair of the walk.
   mcol_level_size u_size (
      .format_code (format_ff),
      .width       (w_ff),
      .height      (h_ff),
      .level_bytes (unit_size)
   );

   // Shared adder: grows the chain sum while walking levels, then adds the
   // whole chain once per preceding face.
   always_comb begin
      if (state_ff == mcol_pkg::ST_FACE) begin
         add_a = off_ff;
         add_b = chain_ff;
      end else begin
         add_a = chain_ff;
         add_b = size_ff;
      end
      add_sum = add_a + add_b;
   end

   always_comb begin
      faces = is_cube_ff ? mcol_pkg::CUBE_FACES : mcol_pkg::FLAT_FACES;
      hit   = (lvl_ff == tgt_level_ff);
      last  = (({1'b0, lvl_ff} + 9'd1) == {1'b0, level_count_ff});
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      lvl_in        = lvl_ff;
      tgt_level_in  = tgt_level_ff;
      face_cnt_in   = face_cnt_ff;
      src_in        = src_ff;
      size_in       = size_ff;
      chain_in      = chain_ff;
      off_in        = off_ff;
      lbytes_in     = lbytes_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_bytes_in  = rsp_bytes_ff;

      unique case (state_ff)
         mcol_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (!storage_ff || !req_source_present) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mcol_pkg::STATUS_NO_SOURCE;
                  rsp_off_in    = '0;
                  rsp_bytes_in  = '0;
               end else if (req_mip_level >= level_count_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mcol_pkg::STATUS_BAD_LEVEL;
                  rsp_off_in    = '0;
                  rsp_bytes_in  = '0;
               end else if (req_face_index >= faces) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mcol_pkg::STATUS_BAD_FACE;
                  rsp_off_in    = '0;
                  rsp_bytes_in  = '0;
               end else begin
                  // start the walk at level zero of the chain
                  w_in         = base_w_ff;
                  h_in         = base_h_ff;
                  lvl_in       = '0;
                  tgt_level_in = req_mip_level;
                  face_cnt_in  = req_face_index[mcol_pkg::FACE_CNT_W-1:0];
                  src_in       = req_source_bytes;
                  chain_in     = '0;
                  off_in       = '0;
                  lbytes_in    = '0;
                  state_in     = mcol_pkg::ST_SIZE;
               end
            end
         end
         mcol_pkg::ST_SIZE: begin
            size_in  = unit_size;
            state_in = mcol_pkg::ST_ACC;
         end
         mcol_pkg::ST_ACC: begin
            if (hit) begin
               off_in    = chain_ff;
               lbytes_in = size_ff;
            end
            chain_in = add_sum;
            w_in     = (w_ff > 16'd1) ? (w_ff >> 1) : 16'd1;
            h_in     = (h_ff > 16'd1) ? (h_ff >> 1) : 16'd1;
            lvl_in   = lvl_ff + 8'd1;
            if ((hit && (face_cnt_ff == '0)) || last) begin
               state_in = mcol_pkg::ST_FACE;
            end else begin
               state_in = mcol_pkg::ST_SIZE;
            end
         end
         mcol_pkg::ST_FACE: begin
            if (face_cnt_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (src_ff > lbytes_ff) ? mcol_pkg::STATUS_TOO_LARGE
                                                    : mcol_pkg::STATUS_OK;
               rsp_off_in    = off_ff;
               rsp_bytes_in  = lbytes_ff;
               state_in      = mcol_pkg::ST_IDLE;
            end else begin
               // skip one whole preceding face chain
               off_in      = add_sum;
               face_cnt_in = face_cnt_ff - 3'd1;
            end
         end
         default: begin
            state_in = mcol_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mcol_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         format_ff      <= 4'd0;
         base_w_ff      <= 16'd1;
         base_h_ff      <= 16'd1;
         level_count_ff <= 8'd1;
         is_cube_ff     <= 1'b0;
         storage_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               mcol_pkg::CSR_FORMAT_CODE:   format_ff      <= csr_wdata[3:0];
               mcol_pkg::CSR_BASE_WIDTH:    base_w_ff      <= csr_wdata;
               mcol_pkg::CSR_BASE_HEIGHT:   base_h_ff      <= csr_wdata;
               mcol_pkg::CSR_LEVEL_COUNT:   level_count_ff <= csr_wdata[7:0];
               mcol_pkg::CSR_IS_CUBE:       is_cube_ff     <= csr_wdata[0];
               mcol_pkg::CSR_STORAGE_READY: storage_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      h_ff          <= h_in;
      lvl_ff        <= lvl_in;
      tgt_level_ff  <= tgt_level_in;
      face_cnt_ff   <= face_cnt_in;
      src_ff        <= src_in;
      size_ff       <= size_in;
      chain_ff      <= chain_in;
      off_ff        <= off_in;
      lbytes_ff     <= lbytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb_mip_chain_offset_locator_unit.sv -----
`timescale 1ns / 1ps

module tb_mip_chain_offset_locator_unit;

   // Register indexes past the end of the list; writes to them must be ignored
   localparam logic [mcol_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [mcol_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   // Any code above the DXT range is an unsupported format
   localparam logic [3:0] FMT_UNSUPPORTED = 4'd12;

   localparam int unsigned CYCLE_LIMIT   = 4000000;
   localparam int unsigned SETTLE_CYCLES = 800;
   localparam int unsigned PHASES        = 16;
   localparam int unsigned PHASE_ITEMS   = 100;

   typedef struct {
      logic [7:0]  mip_level;
      logic [7:0]  face_index;
      logic [31:0] source_bytes;
      logic        source_present;
   } upload_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] byte_offset;
      logic [31:0] level_bytes;
   } placement_type;

   // Shadow of the texture registers plus the queue of placements still owed
   class placement_board;
      logic [3:0]    fmt;
      logic [15:0]   base_w;
      logic [15:0]   base_h;
      logic [7:0]    levels;
      logic          cube;
      logic          ready;
      placement_type awaited[$];
      int unsigned   failures;

      function new();
         fmt = mcol_pkg::FMT_ARGB8;
         base_w = 16'd1;
         base_h = 16'd1;
         levels = 8'd1;
         cube = 1'b0;
         ready = 1'b0;
         failures = 0;
      endfunction

      function void write_register(input logic [mcol_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [mcol_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            mcol_pkg::CSR_FORMAT_CODE:   fmt = data[3:0];
            mcol_pkg::CSR_BASE_WIDTH:    base_w = data;
            mcol_pkg::CSR_BASE_HEIGHT:   base_h = data;
            mcol_pkg::CSR_LEVEL_COUNT:   levels = data[7:0];
            mcol_pkg::CSR_IS_CUBE:       cube = data[0];
            mcol_pkg::CSR_STORAGE_READY: ready = data[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] level_size(input logic [31:0] w, input logic [31:0] h);
         logic [63:0] wide_w;
         logic [63:0] wide_h;
         logic [63:0] total;
         wide_w = {32'd0, w};
         wide_h = {32'd0, h};
         case (fmt)
            mcol_pkg::FMT_ARGB8,
            mcol_pkg::FMT_XRGB8: total = wide_w * wide_h * 64'd4;
            mcol_pkg::FMT_A8L8:  total = wide_w * wide_h * 64'd2;
            mcol_pkg::FMT_L8,
            mcol_pkg::FMT_A8:    total = wide_w * wide_h;
            mcol_pkg::FMT_DXT1:  total = ((wide_w + 64'd3) / 64'd4) *
                                         ((wide_h + 64'd3) / 64'd4) * 64'd8;
            mcol_pkg::FMT_DXT3,
            mcol_pkg::FMT_DXT5:  total = ((wide_w + 64'd3) / 64'd4) *
                                         ((wide_h + 64'd3) / 64'd4) * 64'd16;
            default:             total = 64'd0;
         endcase
         return total[31:0];
      endfunction

      function placement_type locate(input upload_req_type r);
         placement_type p;
         logic [31:0]   w;
         logic [31:0]   h;
         logic [31:0]   size;
         logic [31:0]   offset;
         int            f;
         int            l;
         p.status = mcol_pkg::STATUS_OK;
         p.byte_offset = 32'd0;
         p.level_bytes = 32'd0;
         if (!ready || !r.source_present) begin
            p.status = mcol_pkg::STATUS_NO_SOURCE;
            return p;
         end
         if (r.mip_level >= levels) begin
            p.status = mcol_pkg::STATUS_BAD_LEVEL;
            return p;
         end
         if (r.face_index >= (cube ? mcol_pkg::CUBE_FACES : mcol_pkg::FLAT_FACES)) begin
            p.status = mcol_pkg::STATUS_BAD_FACE;
            return p;
         end
         offset = 32'd0;
         size = 32'd0;
         // Faces are stored back to back, each a full chain of levels
         for (f = 0; f <= r.face_index; f++) begin
            w = {16'd0, base_w};
            h = {16'd0, base_h};
            for (l = 0; l < levels; l++) begin
               size = level_size(w, h);
               if (f == r.face_index && l == r.mip_level) break;
               offset = offset + size;
               // a side of 0 or 1 becomes 1 after halving
               w = (w > 32'd1) ? w / 32'd2 : 32'd1;
               h = (h > 32'd1) ? h / 32'd2 : 32'd1;
            end
         end
         p.status = (r.source_bytes > size) ? mcol_pkg::STATUS_TOO_LARGE
                                            : mcol_pkg::STATUS_OK;
         p.byte_offset = offset;
         p.level_bytes = size;
         return p;
      endfunction

      function void note_request(input upload_req_type r);
         awaited.push_back(locate(r));
      endfunction

      function void check_result(input logic [2:0] status, input logic [31:0] byte_offset,
                                 input logic [31:0] level_bytes);
         placement_type want;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t: result with no request pending: status %0d offset %h bytes %h",
                     $time, status, byte_offset, level_bytes);
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            failures++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
         end
         if (byte_offset !== want.byte_offset) begin
            failures++;
            $display("%0t: byte_offset mismatch: expected %h, actual %h",
                     $time, want.byte_offset, byte_offset);
         end
         if (level_bytes !== want.level_bytes) begin
            failures++;
            $display("%0t: level_bytes mismatch: expected %h, actual %h",
                     $time, want.level_bytes, level_bytes);
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [7:0]                           req_mip_level;
   logic [7:0]                           req_face_index;
   logic [mcol_pkg::BYTES_W-1:0]         req_source_bytes;
   logic                                 req_source_present;
   logic                                 rsp_valid;
   logic [2:0]                           rsp_status;
   logic [mcol_pkg::BYTES_W-1:0]         rsp_byte_offset;
   logic [mcol_pkg::BYTES_W-1:0]         rsp_level_bytes;
   logic                                 csr_we;
   logic [mcol_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [mcol_pkg::CSR_DATA_W-1:0]      csr_wdata;

   placement_board board;
   int unsigned    cycle_count = 0;

   mip_chain_offset_locator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mip_level      (req_mip_level),
      .req_face_index     (req_face_index),
      .req_source_bytes   (req_source_bytes),
      .req_source_present (req_source_present),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_level_bytes    (rsp_level_bytes),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results cannot be held off: take every strobed result at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_status, rsp_byte_offset, rsp_level_bytes);
   end

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Hold until every owed placement has come back and the block is idle
   task automatic wait_until_drained();
      while (board.awaited.size() != 0 || busy) @(posedge clock);
   endtask

   // Write one register; leave csr_we high so back-to-back writes need no toggle
   task automatic write_register(input logic [mcol_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [mcol_pkg::CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we <= 1'b1;
      @(posedge clock);
      board.write_register(idx, data);
   endtask

   // Program a full texture description; unused upper data bits carry noise
   task automatic load_setting(input logic [3:0] fmt, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] lc,
                               input logic cube, input logic ready);
      logic [31:0] noise;
      wait_until_drained();
      noise = $urandom();
      write_register(mcol_pkg::CSR_FORMAT_CODE, {noise[15:4], fmt});
      write_register(mcol_pkg::CSR_BASE_WIDTH, w);
      write_register(mcol_pkg::CSR_BASE_HEIGHT, h);
      noise = $urandom();
      write_register(mcol_pkg::CSR_LEVEL_COUNT, {noise[7:0], lc});
      noise = $urandom();
      write_register(mcol_pkg::CSR_IS_CUBE, {noise[14:0], cube});
      write_register(mcol_pkg::CSR_STORAGE_READY, {noise[30:16], ready});
      // poke a register that does not exist; nothing may change
      noise = $urandom();
      write_register(noise[16] ? CSR_SPARE_HI : CSR_SPARE_LO, noise[15:0]);
      csr_we <= 1'b0;
   endtask

   // Present one request and hold it until accepted, then idle at random.
   // Keep start high when the next request follows at once; drop it otherwise.
   task automatic send_request(input upload_req_type r, input int idle_pct, input bit last);
      int gap;
      gap = 0;
      req_mip_level <= r.mip_level;
      req_face_index <= r.face_index;
      req_source_bytes <= r.source_bytes;
      req_source_present <= r.source_present;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(r);
      while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0 || last) start <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic try_upload(input logic [7:0] level, input logic [7:0] face,
                             input logic [31:0] src, input logic present);
      upload_req_type r;
      r.mip_level = level;
      r.face_index = face;
      r.source_bytes = src;
      r.source_present = present;
      send_request(r, 0, 1'b1);
   endtask

   // Send a request whose length sits at the level size plus a small delta
   task automatic try_sized(input logic [7:0] level, input logic [7:0] face,
                            input logic [31:0] delta);
      upload_req_type r;
      placement_type  p;
      r.mip_level = level;
      r.face_index = face;
      r.source_bytes = 32'd0;
      r.source_present = 1'b1;
      p = board.locate(r);
      r.source_bytes = p.level_bytes + delta;
      send_request(r, 0, 1'b1);
   endtask

   task automatic sweep_format(input logic [3:0] fmt, input logic [7:0] level,
                               input logic [7:0] face);
      load_setting(fmt, 16'd13, 16'd5, 8'd5, 1'b1, 1'b1);
      try_sized(level, face, 32'd0);
   endtask

   // Mostly small sides, now and then zero or the full range
   function automatic logic [15:0] random_side();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'($urandom_range(65535));
         2:       return 16'hFFFF;
         default: return 16'($urandom_range(64, 1));
      endcase
   endfunction

   // Mostly well-formed requests sized around the level they hit, plus noise
   function automatic upload_req_type random_request();
      upload_req_type r;
      placement_type  p;
      r.source_present = ($urandom_range(19) != 0);
      if (board.levels != 0 && $urandom_range(9) != 0)
         r.mip_level = 8'($urandom_range(board.levels - 1));
      else
         r.mip_level = 8'($urandom_range(255));
      if ($urandom_range(9) != 0)
         r.face_index = 8'($urandom_range(
            (board.cube ? mcol_pkg::CUBE_FACES : mcol_pkg::FLAT_FACES) - 1));
      else
         r.face_index = 8'($urandom_range(255));
      r.source_bytes = 32'd0;
      p = board.locate(r);
      case ($urandom_range(5))
         0: r.source_bytes = p.level_bytes;
         1: r.source_bytes = p.level_bytes - 32'd1;
         2: r.source_bytes = p.level_bytes + 32'd1;
         3: r.source_bytes = $urandom();
         4: r.source_bytes = 32'd0;
         default: r.source_bytes = $urandom_range(p.level_bytes);
      endcase
      return r;
   endfunction

   initial begin
      int          phase;
      int          i;
      int          idle_pct;
      bit          pause;
      logic [3:0]  pick_fmt;
      logic [7:0]  pick_lc;

      board = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_mip_level <= 8'd0;
      req_face_index <= 8'd0;
      req_source_bytes <= 32'd0;
      req_source_present <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= mcol_pkg::CSR_FORMAT_CODE;
      csr_wdata <= 16'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Out of reset no storage exists: any request is turned away
      try_upload(8'd0, 8'd0, 32'd0, 1'b1);

      // Largest cube: sizes wrap, every rejection reason, exact and one-over lengths
      load_setting(mcol_pkg::FMT_ARGB8, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1, 1'b1);
      try_upload(8'd0, 8'd0, 32'd0, 1'b1);
      try_upload(8'd254, 8'd5, 32'hFFFF_FFFF, 1'b1);
      try_upload(8'd255, 8'd0, 32'd0, 1'b1);
      try_upload(8'd0, 8'd6, 32'd0, 1'b1);
      try_upload(8'd0, 8'd255, 32'd0, 1'b1);
      try_upload(8'd0, 8'd0, 32'd0, 1'b0);
      try_sized(8'd3, 8'd2, 32'd0);
      try_sized(8'd3, 8'd2, 32'd1);

      // Zero width on a flat block-compressed texture; second face is out of range
      load_setting(mcol_pkg::FMT_DXT5, 16'd0, 16'd7, 8'd4, 1'b0, 1'b1);
      try_sized(8'd0, 8'd0, 32'd0);
      try_sized(8'd3, 8'd0, 32'd1);
      try_upload(8'd1, 8'd1, 32'd0, 1'b1);

      // Unsupported format: every level is empty, only a zero length fits
      load_setting(FMT_UNSUPPORTED, 16'd9, 16'd9, 8'd3, 1'b1, 1'b1);
      try_upload(8'd2, 8'd3, 32'd0, 1'b1);
      try_upload(8'd2, 8'd3, 32'd1, 1'b1);

      // No levels at all: the level check rejects everything
      load_setting(mcol_pkg::FMT_L8, 16'd1, 16'd1, 8'd0, 1'b1, 1'b1);
      try_upload(8'd0, 8'd0, 32'd0, 1'b1);

      // One request per supported format on an odd-sized cube
      sweep_format(mcol_pkg::FMT_ARGB8, 8'd0, 8'd5);
      sweep_format(mcol_pkg::FMT_XRGB8, 8'd1, 8'd4);
      sweep_format(mcol_pkg::FMT_A8L8, 8'd2, 8'd3);
      sweep_format(mcol_pkg::FMT_L8, 8'd3, 8'd2);
      sweep_format(mcol_pkg::FMT_A8, 8'd4, 8'd1);
      sweep_format(mcol_pkg::FMT_DXT1, 8'd0, 8'd0);
      sweep_format(mcol_pkg::FMT_DXT3, 8'd1, 8'd5);
      sweep_format(mcol_pkg::FMT_DXT5, 8'd4, 8'd3);

      // Random phases: a fresh texture each, idling pattern rotating per phase
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            1:       idle_pct = 51;
            3:       idle_pct = 29;
            default: idle_pct = 0;
         endcase
         pick_fmt = ($urandom_range(4) != 0) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
         case ($urandom_range(9))
            0:       pick_lc = 8'd0;
            default: pick_lc = 8'($urandom_range(12, 1));
         endcase
         // one phase walks the longest chain the block allows
         if (phase == 7)
            pick_lc = 8'd255;
         load_setting(pick_fmt, random_side(), random_side(), pick_lc,
                      1'($urandom_range(1)), ($urandom_range(9) != 0));
         for (i = 0; i < PHASE_ITEMS; i++) begin
            pause = (phase % 3 == 1) && (i == PHASE_ITEMS / 2);
            send_request(random_request(), idle_pct, pause || i == PHASE_ITEMS - 1);
            // let the block run dry mid-phase before resuming
            if (pause)
               wait_until_drained();
         end
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
